### src/adts_header_sync_detector_macros.svh
// ----------------------------------------------------------------------------
// adts header sync detector assertion macros
// concurrent assertion forms used by the history module
// ----------------------------------------------------------------------------
`ifndef ADTS_HEADER_SYNC_DETECTOR_MACROS_SVH
`define ADTS_HEADER_SYNC_DETECTOR_MACROS_SVH

// same-cycle implication under reset
`define ADTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("adts sync detector check failed");

// next-cycle implication under reset
`define ADTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("adts sync detector check failed");

`endif

### src/adts_pkg.sv
// ----------------------------------------------------------------------------
// adts_pkg
// types, constants and lookup tables of the adts header sync detector
// ----------------------------------------------------------------------------
package adts_pkg;

  localparam int unsigned HistW  = 64;
  localparam int unsigned HdrW   = 56;
  localparam int unsigned OutW   = 128;
  localparam logic [2:0]  SkipAfterRun = 3'd5;
  localparam logic [11:0] SyncWord     = 12'hFFF;
  localparam logic [12:0] MinFrameLen  = 13'd7;

  // candidate window between history and decode stages
  typedef struct packed {
    logic            vld;
    logic [HdrW-1:0] hdr;
  } win_t;

  // sampling frequency by index, zero for reserved codes
  function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // channel count by configuration, configuration seven gives eight
  function automatic logic [3:0] chan_lookup(input logic [2:0] cfg);
    logic [3:0] c;
    case (cfg)
      3'd7:    c = 4'd8;
      default: c = {1'b0, cfg};
    endcase
    return c;
  endfunction

endpackage

### src/adts_hist.sv
// ----------------------------------------------------------------------------
// adts_hist
// byte history, skip counter and sync search; registers the candidate window
// ----------------------------------------------------------------------------
`include "adts_header_sync_detector_macros.svh"

module adts_hist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  output logic            in_rdy_o,
  input  logic [7:0]      data_byte_i,
  input  logic            restart_i,
  input  logic            win_take_i,
  output adts_pkg::win_t  win_o
);
  import adts_pkg::*;

  logic [HistW-1:0] hist_q, hist_d;
  logic [2:0]       skip_q, skip_d;
  win_t             win_q, win_d;
  logic             accept;
  logic [HistW-1:0] hist_base;
  logic [2:0]       skip_base;
  logic [HistW-1:0] hist_shift;
  logic             all_ones;
  logic             cand;

  assign in_rdy_o = win_take_i;
  assign accept   = in_vld_i & win_take_i;

  // restart clears state ahead of this beat
  assign hist_base  = restart_i ? '0 : hist_q;
  assign skip_base  = restart_i ? '0 : skip_q;
  assign hist_shift = {hist_base[HistW-9:0], data_byte_i};
  assign all_ones   = &hist_shift;

  // next history, skip count and candidate flag
  always_comb begin
    hist_d = hist_q;
    skip_d = skip_q;
    cand   = 1'b0;
    if (accept) begin
      if (skip_base != 3'd0) begin
        hist_d = hist_base;
        skip_d = skip_base - 3'd1;
      end else begin
        hist_d = hist_shift;
        if (all_ones) begin
          skip_d = SkipAfterRun;
        end else begin
          skip_d = 3'd0;
          cand   = !(&hist_shift[HdrW-1:HdrW-16]) &&
                   (hist_shift[HdrW-1:HdrW-12] == SyncWord);
        end
      end
    end
  end

  // window stage load and drain
  always_comb begin
    win_d = win_q;
    if (accept) begin
      win_d.vld = cand;
      win_d.hdr = hist_shift[HdrW-1:0];
    end else if (win_take_i) begin
      win_d.vld = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      skip_q <= '0;
      win_q  <= '0;
    end else begin
      hist_q <= hist_d;
      skip_q <= skip_d;
      win_q  <= win_d;
    end
  end

  assign win_o = win_q;

  // skipping only ever happens on an all-ones history
  `ADTS_ASSERT_IMP(a_skip_ones, clk_i, rst_ni, skip_q != 3'd0, &hist_q)
  // skip count never exceeds its load value
  `ADTS_ASSERT_IMP(a_skip_max, clk_i, rst_ni, 1'b1, skip_q <= SkipAfterRun)
  // an ignored byte never yields a candidate
  `ADTS_ASSERT_NXT(a_skip_quiet, clk_i, rst_ni,
    accept && !restart_i && (skip_q != 3'd0), !win_q.vld)

endmodule

### src/adts_dec.sv
// ----------------------------------------------------------------------------
// adts_dec
// header field decode, validity checks and the result register
// ----------------------------------------------------------------------------
module adts_dec (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  adts_pkg::win_t           win_i,
  output logic                     win_take_o,
  output logic                     out_vld_o,
  input  logic                     out_rdy_i,
  output logic [adts_pkg::OutW-1:0] out_data_o
);
  import adts_pkg::*;

  logic [HdrW-1:0] w;
  logic [3:0]      srix;
  logic [2:0]      chcf;
  logic [12:0]     flen;
  logic [16:0]     rate;
  logic [3:0]      chans;
  logic [2:0]      blocks;
  logic [12:0]     total;
  logic            emit;
  logic            out_free;
  logic            out_vld_q;
  logic [OutW-1:0] out_q, out_d;

  // field extraction and table lookups
  assign w      = win_i.hdr;
  assign flen   = w[25:13];
  assign srix   = w[37:34];
  assign chcf   = w[32:30];
  assign rate   = rate_lookup(srix);
  assign chans  = chan_lookup(chcf);
  assign blocks = {1'b0, w[1:0]} + 3'd1;
  assign total  = {blocks, 10'd0};

  assign emit = win_i.vld && (flen >= MinFrameLen) && (rate != '0) && (chans != '0);

  // result packing, highest field first
  assign out_d = {total, chans, rate, blocks, w[12:2], flen, chcf, srix,
                  w[39:38], w[40], w[43], w};

  assign out_free   = !out_vld_q || out_rdy_i;
  assign win_take_o = !emit || out_free;

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

endmodule

### src/adts_header_sync_detector.sv
// path: an accepted byte registers its header window in adts_hist; adts_dec then registers the header result
// throughput: one byte per cycle unless the output stalls input; the history and skip update is combinational
// a header result waiting at the output stalls input only when a second one is ready
// reset: asynchronous active low, clears history, skip count and both valid flags
// ----------------------------------------------------------------------------
// adts_header_sync_detector
// byte-stream search for adts headers with field decode and table lookups
// ----------------------------------------------------------------------------
module adts_header_sync_detector (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // data_byte
  input  logic          s_axis_tuser,   // restart
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // header_bits, version_id, protection_absent, profile, freq_index,
  // channel_config, frame_length, buf_level, raw_block_count,
  // sample_rate_hz, channel_count, sample_total
  output logic [127:0]  m_axis_tdata
);
  import adts_pkg::*;

  win_t win;
  logic win_take;

  // history and sync search stage
  adts_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (s_axis_tvalid),
    .in_rdy_o    (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .restart_i   (s_axis_tuser),
    .win_take_i  (win_take),
    .win_o       (win)
  );

  // decode and result stage
  adts_dec u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_i      (win),
    .win_take_o (win_take),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
